// ===== rtl/hpfm_pkg.sv =====
// hpfm_pkg: shared types, widths and constants of the homography forward map
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package hpfm_pkg;

    // field and arithmetic widths
    localparam int COORD_BITS      = 12;
    localparam int COEF_W          = 32;
    localparam int COEF_FRAC_BITS  = 20;
    localparam int PROD_W          = COORD_BITS + COEF_W;
    localparam int SUM_W           = PROD_W + 2;
    localparam int QUOT_FRAC       = 8;
    localparam int MAG_W           = SUM_W + QUOT_FRAC;
    localparam int QUOT_BITS       = 21;
    localparam int CMP_W           = SUM_W + QUOT_BITS;
    localparam int QS_W            = QUOT_BITS + 3;
    localparam int LIM_W           = 13;
    localparam int DEST_W          = 12;
    localparam int PIX_W           = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LIMIT_MAX       = 4096;
    localparam int MAP_OFFSET      = 500;
    localparam int LIM_RESET       = 1024;

    // pipeline depths
    localparam int MAC_LAT         = 2;
    localparam int DIV_LAT         = QUOT_BITS + 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0B_ROW1A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_B      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_A      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS    = 3'd6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] src_x;
        logic signed [COORD_BITS-1:0] src_y;
        logic [PIX_W-1:0]             pixel_in;
    } t_req;

    typedef struct packed {
        logic [DEST_W-1:0] dest_col;
        logic [DEST_W-1:0] dest_row;
        logic [PIX_W-1:0]  pixel_out;
        logic              in_range;
    } t_res;

    // coefficient set and saturated limits handed to the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] h00;
        logic signed [COEF_W-1:0] h01;
        logic signed [COEF_W-1:0] h02;
        logic signed [COEF_W-1:0] h10;
        logic signed [COEF_W-1:0] h11;
        logic signed [COEF_W-1:0] h12;
        logic signed [COEF_W-1:0] h20;
        logic signed [COEF_W-1:0] h21;
        logic signed [COEF_W-1:0] h22;
        logic [LIM_W-1:0]         cols;
        logic [LIM_W-1:0]         rows;
    } t_coef;

    // quotient result of one divider lane
    typedef struct packed {
        logic [QUOT_BITS-1:0] quo;
        logic                 rem_nz;
        logic                 neg;
        logic                 ovf;
        logic                 zero;
    } t_quot;

endpackage
`default_nettype wire

// ===== rtl/hpfm_cfg.sv =====
// hpfm_cfg: configuration register file of the homography forward map
// depends on hpfm_pkg
`timescale 1ns / 1ps
`default_nettype none
module hpfm_cfg #(
    parameter int COEF_FRAC_BITS = hpfm_pkg::COEF_FRAC_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [hpfm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hpfm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output hpfm_pkg::t_coef                       o_coef
);
    localparam logic [hpfm_pkg::CFG_DATA_W-1:0] ONE_Q =
        hpfm_pkg::CFG_DATA_W'(64'd1 << COEF_FRAC_BITS);
    localparam logic [hpfm_pkg::LIM_W-1:0] LIM_MAX =
        hpfm_pkg::LIM_W'(hpfm_pkg::LIMIT_MAX);

    logic [hpfm_pkg::CFG_DATA_W-1:0] r_row0_a, r_row0b_row1a, r_row1_b, r_row2_a;
    logic [hpfm_pkg::COEF_W-1:0]     r_row2_c;
    logic [hpfm_pkg::LIM_W-1:0]      r_cols, r_rows;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_a      <= ONE_Q;
            r_row0b_row1a <= '0;
            r_row1_b      <= ONE_Q;
            r_row2_a      <= '0;
            r_row2_c      <= hpfm_pkg::COEF_W'(ONE_Q);
            r_cols        <= hpfm_pkg::LIM_W'(hpfm_pkg::LIM_RESET);
            r_rows        <= hpfm_pkg::LIM_W'(hpfm_pkg::LIM_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hpfm_pkg::REG_ROW0_A:      r_row0_a      <= i_cfg_data;
                hpfm_pkg::REG_ROW0B_ROW1A: r_row0b_row1a <= i_cfg_data;
                hpfm_pkg::REG_ROW1_B:      r_row1_b      <= i_cfg_data;
                hpfm_pkg::REG_ROW2_A:      r_row2_a      <= i_cfg_data;
                hpfm_pkg::REG_ROW2_C:      r_row2_c      <= i_cfg_data[hpfm_pkg::COEF_W-1:0];
                hpfm_pkg::REG_OUT_COLS:    r_cols        <= i_cfg_data[hpfm_pkg::LIM_W-1:0];
                hpfm_pkg::REG_OUT_ROWS:    r_rows        <= i_cfg_data[hpfm_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack coefficients and saturate limits
    always_comb begin
        o_coef.h00  = $signed(r_row0_a[31:0]);
        o_coef.h01  = $signed(r_row0_a[63:32]);
        o_coef.h02  = $signed(r_row0b_row1a[31:0]);
        o_coef.h10  = $signed(r_row0b_row1a[63:32]);
        o_coef.h11  = $signed(r_row1_b[31:0]);
        o_coef.h12  = $signed(r_row1_b[63:32]);
        o_coef.h20  = $signed(r_row2_a[31:0]);
        o_coef.h21  = $signed(r_row2_a[63:32]);
        o_coef.h22  = $signed(r_row2_c);
        o_coef.cols = (r_cols > LIM_MAX) ? LIM_MAX : r_cols;
        o_coef.rows = (r_rows > LIM_MAX) ? LIM_MAX : r_rows;
    end
endmodule
`default_nettype wire

// ===== rtl/hpfm_mac.sv =====
// hpfm_mac: two-stage multiply and sum forming both numerators and the denominator
// depends on hpfm_pkg
`timescale 1ns / 1ps
`default_nettype none
module hpfm_mac (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_vld,
    input  wire hpfm_pkg::t_req                      i_req,
    input  wire hpfm_pkg::t_coef                     i_coef,
    output logic                                     o_vld,
    output logic signed [hpfm_pkg::SUM_W-1:0]        o_nx,
    output logic signed [hpfm_pkg::SUM_W-1:0]        o_ny,
    output logic signed [hpfm_pkg::SUM_W-1:0]        o_z
);
    localparam int PW = hpfm_pkg::PROD_W;
    localparam int SW = hpfm_pkg::SUM_W;

    logic                 r_vld1, r_vld2;
    logic signed [PW-1:0] r_px0, r_py0, r_px1, r_py1, r_px2, r_py2;
    logic signed [SW-1:0] r_c0, r_c1, r_c2;
    logic signed [SW-1:0] r_nx, r_ny, r_z;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // stage 1: six products, constant terms registered alongside
    always_ff @(posedge i_clk) begin
        r_px0 <= i_req.src_x * i_coef.h00;
        r_py0 <= i_req.src_y * i_coef.h01;
        r_px1 <= i_req.src_x * i_coef.h10;
        r_py1 <= i_req.src_y * i_coef.h11;
        r_px2 <= i_req.src_x * i_coef.h20;
        r_py2 <= i_req.src_y * i_coef.h21;
        r_c0  <= SW'(i_coef.h02);
        r_c1  <= SW'(i_coef.h12);
        r_c2  <= SW'(i_coef.h22);
    end

    // stage 2: three-term sums
    always_ff @(posedge i_clk) begin
        r_nx <= SW'(r_px0) + SW'(r_py0) + r_c0;
        r_ny <= SW'(r_px1) + SW'(r_py1) + r_c1;
        r_z  <= SW'(r_px2) + SW'(r_py2) + r_c2;
    end

    assign o_vld = r_vld2;
    assign o_nx  = r_nx;
    assign o_ny  = r_ny;
    assign o_z   = r_z;
endmodule
`default_nettype wire

// ===== rtl/hpfm_div.sv =====
// hpfm_div: pipelined restoring divider, one quotient bit per stage
// depends on hpfm_pkg
`timescale 1ns / 1ps
`default_nettype none
module hpfm_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_vld,
    input  wire logic signed [hpfm_pkg::SUM_W-1:0]   i_num,
    input  wire logic signed [hpfm_pkg::SUM_W-1:0]   i_den,
    output logic                                     o_vld,
    output hpfm_pkg::t_quot                          o_quot
);
    localparam int SW = hpfm_pkg::SUM_W;
    localparam int AW = hpfm_pkg::MAG_W;
    localparam int DW = hpfm_pkg::CMP_W;
    localparam int QB = hpfm_pkg::QUOT_BITS;
    localparam int QF = hpfm_pkg::QUOT_FRAC;

    logic [SW-1:0] n_nmag, n_dmag;

    // front stage: magnitudes and sign
    logic          r_vld_a, r_neg_a, r_zero_a;
    logic [AW-1:0] r_a;
    logic [SW-1:0] r_b_a;

    // bit stages, index 0 is the range check stage
    logic          r_vld [0:QB];
    logic [AW-1:0] r_rem [0:QB];
    logic [SW-1:0] r_b   [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];
    logic          r_zero[0:QB];

    always_comb begin
        n_nmag = i_num[SW-1] ? SW'(-i_num) : SW'(i_num);
        n_dmag = i_den[SW-1] ? SW'(-i_den) : SW'(i_den);
    end

    // magnitudes, scaled numerator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= {n_nmag, {QF{1'b0}}};
        r_b_a    <= n_dmag;
        r_neg_a  <= i_num[SW-1] ^ i_den[SW-1];
        r_zero_a <= (i_den == '0);
    end

    // quotient too large for the output window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= r_a;
        r_b[0]    <= r_b_a;
        r_quo[0]  <= '0;
        r_neg[0]  <= r_neg_a;
        r_zero[0] <= r_zero_a;
        r_ovf[0]  <= DW'(r_a) >= (DW'(r_b_a) << QB);
    end

    // one trial subtraction per stage, most significant bit first
    for (genvar k = 0; k < QB; k++) begin : g_bit
        localparam int BP = QB - 1 - k;
        logic [DW-1:0] n_sh;
        logic          n_ge;

        always_comb begin
            n_sh = DW'(r_b[k]) << BP;
            n_ge = DW'(r_rem[k]) >= n_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_ge ? AW'(DW'(r_rem[k]) - n_sh) : r_rem[k];
            r_quo[k+1]  <= {r_quo[k][QB-2:0], n_ge};
            r_b[k+1]    <= r_b[k];
            r_neg[k+1]  <= r_neg[k];
            r_ovf[k+1]  <= r_ovf[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    assign o_vld         = r_vld[QB];
    assign o_quot.quo    = r_quo[QB];
    assign o_quot.rem_nz = (r_rem[QB] != '0);
    assign o_quot.neg    = r_neg[QB];
    assign o_quot.ovf    = r_ovf[QB];
    assign o_quot.zero   = r_zero[QB];
endmodule
`default_nettype wire

// ===== rtl/hpfm_post.sv =====
// hpfm_post: floor correction, offset, range test, rounding and clamping
// depends on hpfm_pkg
`timescale 1ns / 1ps
`default_nettype none
module hpfm_post (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_vld,
    input  wire hpfm_pkg::t_quot                 i_qx,
    input  wire hpfm_pkg::t_quot                 i_qy,
    input  wire logic [hpfm_pkg::PIX_W-1:0]      i_pix,
    input  wire hpfm_pkg::t_coef                 i_coef,
    output logic                                 o_done,
    output hpfm_pkg::t_res                       o_res
);
    localparam int QW = hpfm_pkg::QS_W;
    localparam int QB = hpfm_pkg::QUOT_BITS;
    localparam int QF = hpfm_pkg::QUOT_FRAC;
    localparam int LW = hpfm_pkg::LIM_W;
    localparam logic signed [QW-1:0] OFFSET_Q = QW'(hpfm_pkg::MAP_OFFSET << QF);
    localparam logic signed [QW-1:0] HALF_Q   = QW'(1 << (QF - 1));

    logic signed [QW-1:0] n_qx, n_qy;
    logic signed [QW-1:0] r_qx, r_qy;
    logic                 r_vld, r_bad;
    logic [hpfm_pkg::PIX_W-1:0] r_pix;

    logic signed [QW-1:0] n_clim, n_rlim, n_rx, n_ry;
    logic [LW-1:0]        n_dx, n_dy, n_cx, n_cy;
    logic                 n_ok;
    logic                 r_done;
    hpfm_pkg::t_res       r_res;

    // signed floor quotient plus offset
    function automatic logic signed [QW-1:0] f_floor(input hpfm_pkg::t_quot q);
        logic signed [QW-1:0] m;
        m = $signed({{(QW-QB){1'b0}}, q.quo});
        return q.neg ? (-m - QW'(q.rem_nz)) : m;
    endfunction

    always_comb begin
        n_qx = f_floor(i_qx) + OFFSET_Q;
        n_qy = f_floor(i_qy) + OFFSET_Q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx  <= n_qx;
        r_qy  <= n_qy;
        r_bad <= i_qx.ovf | i_qy.ovf | i_qx.zero | i_qy.zero;
        r_pix <= i_pix;
    end

    // range test and round half up with clamp
    always_comb begin
        n_clim = $signed({{(QW-LW-QF){1'b0}}, i_coef.cols, {QF{1'b0}}});
        n_rlim = $signed({{(QW-LW-QF){1'b0}}, i_coef.rows, {QF{1'b0}}});
        n_ok   = !r_bad && (r_qx > 0) && (r_qy > 0) && (r_qx < n_clim) && (r_qy < n_rlim);
        n_rx   = r_qx + HALF_Q;
        n_ry   = r_qy + HALF_Q;
        n_dx   = n_rx[LW+QF-1:QF];
        n_dy   = n_ry[LW+QF-1:QF];
        n_cx   = (n_dx >= i_coef.cols) ? (i_coef.cols - LW'(1)) : n_dx;
        n_cy   = (n_dy >= i_coef.rows) ? (i_coef.rows - LW'(1)) : n_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.dest_col  <= n_ok ? n_cx[hpfm_pkg::DEST_W-1:0] : '0;
        r_res.dest_row  <= n_ok ? n_cy[hpfm_pkg::DEST_W-1:0] : '0;
        r_res.pixel_out <= r_pix;
        r_res.in_range  <= n_ok;
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

// ===== rtl/homography_pixel_forward_map_unit.sv =====
// homography_pixel_forward_map_unit: top level of the homography forward map
// depends on hpfm_pkg, hpfm_cfg, hpfm_mac, hpfm_div, hpfm_post
`timescale 1ns / 1ps
`default_nettype none
// Maps one source pixel per clock through a 3x3 homography. A request is taken
// on every cycle with i_start high; o_busy is never raised. Each request gives
// exactly one result, on o_res for a single cycle with o_done high, once it has passed
// two multiply/sum stages, two divider set-up stages, 21 one-bit divider stages
// and two output stages. The receiver cannot stall the
// block, so it must take every result as it appears. Configuration writes are
// always accepted and should be made only with no request in flight.
module homography_pixel_forward_map_unit #(
    parameter int COEF_FRAC_BITS = hpfm_pkg::COEF_FRAC_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire hpfm_pkg::t_req                   i_req,
    output logic                                  o_done,
    output hpfm_pkg::t_res                        o_res,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [hpfm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hpfm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int PD = hpfm_pkg::MAC_LAT + hpfm_pkg::DIV_LAT;

    hpfm_pkg::t_coef                  coef;
    logic                             mac_vld, divx_vld, divy_vld;
    logic signed [hpfm_pkg::SUM_W-1:0] nx, ny, z;
    hpfm_pkg::t_quot                  qx, qy;
    logic [hpfm_pkg::PIX_W-1:0]       r_pix [0:PD-1];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    hpfm_cfg #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_coef     (coef)
    );

    // numerators and denominator
    hpfm_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_start),
        .i_req  (i_req),
        .i_coef (coef),
        .o_vld  (mac_vld),
        .o_nx   (nx),
        .o_ny   (ny),
        .o_z    (z)
    );

    // column and row dividers
    hpfm_div u_divx (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (mac_vld),
        .i_num  (nx),
        .i_den  (z),
        .o_vld  (divx_vld),
        .o_quot (qx)
    );

    hpfm_div u_divy (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (mac_vld),
        .i_num  (ny),
        .i_den  (z),
        .o_vld  (divy_vld),
        .o_quot (qy)
    );

    // gray value delay matching the arithmetic
    always_ff @(posedge i_clk) begin
        r_pix[0] <= i_req.pixel_in;
        for (int i = 1; i < PD; i++) begin
            r_pix[i] <= r_pix[i-1];
        end
    end

    // output stage
    hpfm_post u_post (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (divx_vld & divy_vld),
        .i_qx   (qx),
        .i_qy   (qy),
        .i_pix  (r_pix[PD-1]),
        .i_coef (coef),
        .o_done (o_done),
        .o_res  (o_res)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tb_homography_pixel_forward_map_unit.sv =====
// tb_homography_pixel_forward_map_unit: self-checking bench for the homography forward map
// depends on hpfm_pkg and homography_pixel_forward_map_unit
`timescale 1ns / 1ps
module tb_homography_pixel_forward_map_unit;

    localparam int CLK_HALF = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 40;
    localparam int RAND_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 70;
    localparam logic [hpfm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // destination map predictor with its own register copy and queue of expected pixels
    class map_scoreboard;
        logic [63:0]     regs [7];
        hpfm_pkg::t_res  due_q [$];
        int              errors;

        function new();
            regs[hpfm_pkg::REG_ROW0_A]      = 64'h0000_0000_0010_0000;
            regs[hpfm_pkg::REG_ROW0B_ROW1A] = 64'h0;
            regs[hpfm_pkg::REG_ROW1_B]      = 64'h0000_0000_0010_0000;
            regs[hpfm_pkg::REG_ROW2_A]      = 64'h0;
            regs[hpfm_pkg::REG_ROW2_C]      = 64'h0010_0000;
            regs[hpfm_pkg::REG_OUT_COLS]    = hpfm_pkg::LIM_RESET;
            regs[hpfm_pkg::REG_OUT_ROWS]    = hpfm_pkg::LIM_RESET;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [hpfm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                hpfm_pkg::REG_ROW0_A, hpfm_pkg::REG_ROW0B_ROW1A,
                hpfm_pkg::REG_ROW1_B, hpfm_pkg::REG_ROW2_A: regs[idx] = data;
                hpfm_pkg::REG_ROW2_C: regs[idx] = {32'h0, data[31:0]};
                hpfm_pkg::REG_OUT_COLS, hpfm_pkg::REG_OUT_ROWS: regs[idx] = {51'h0, data[12:0]};
                default: ;
            endcase
        endfunction

        // quotient rounded towards minus infinity
        function longint floor_quot(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && ((a < 0) != (b < 0)))
                q = q - 1;
            return q;
        endfunction

        function longint lim(logic [63:0] v);
            return (v > hpfm_pkg::LIMIT_MAX) ? hpfm_pkg::LIMIT_MAX : longint'(v);
        endfunction

        function void note(hpfm_pkg::t_req r);
            longint x, y, z, nx, ny, qx, qy, cols, rows, dc, dr;
            hpfm_pkg::t_res e;
            x = r.src_x;
            y = r.src_y;
            z  = x * longint'($signed(regs[hpfm_pkg::REG_ROW2_A][31:0]))
               + y * longint'($signed(regs[hpfm_pkg::REG_ROW2_A][63:32]))
               + longint'($signed(regs[hpfm_pkg::REG_ROW2_C][31:0]));
            nx = x * longint'($signed(regs[hpfm_pkg::REG_ROW0_A][31:0]))
               + y * longint'($signed(regs[hpfm_pkg::REG_ROW0_A][63:32]))
               + longint'($signed(regs[hpfm_pkg::REG_ROW0B_ROW1A][31:0]));
            ny = x * longint'($signed(regs[hpfm_pkg::REG_ROW0B_ROW1A][63:32]))
               + y * longint'($signed(regs[hpfm_pkg::REG_ROW1_B][31:0]))
               + longint'($signed(regs[hpfm_pkg::REG_ROW1_B][63:32]));
            cols = lim(regs[hpfm_pkg::REG_OUT_COLS]);
            rows = lim(regs[hpfm_pkg::REG_OUT_ROWS]);
            e = '0;
            e.pixel_out = r.pixel_in;
            if (z != 0) begin
                qx = floor_quot(nx * 256, z) + hpfm_pkg::MAP_OFFSET * 256;
                qy = floor_quot(ny * 256, z) + hpfm_pkg::MAP_OFFSET * 256;
                if (qx > 0 && qy > 0 && qx < cols * 256 && qy < rows * 256) begin
                    // round half up, then clamp a hit on the edge back inside
                    dc = (qx + 128) >>> 8;
                    dr = (qy + 128) >>> 8;
                    if (dc >= cols) dc = cols - 1;
                    if (dr >= rows) dr = rows - 1;
                    e.in_range = 1'b1;
                    e.dest_col = dc[hpfm_pkg::DEST_W-1:0];
                    e.dest_row = dr[hpfm_pkg::DEST_W-1:0];
                end
            end
            due_q = {due_q, e};
        endfunction

        task check(hpfm_pkg::t_res got);
            hpfm_pkg::t_res e;
            if (due_q.size() == 0) begin
                report("result with nothing outstanding");
                return;
            end
            e = due_q.pop_front();
            if (got.dest_col !== e.dest_col)
                report($sformatf("dest_col %0d want %0d", got.dest_col, e.dest_col));
            if (got.dest_row !== e.dest_row)
                report($sformatf("dest_row %0d want %0d", got.dest_row, e.dest_row));
            if (got.pixel_out !== e.pixel_out)
                report($sformatf("pixel_out %0d want %0d", got.pixel_out, e.pixel_out));
            if (got.in_range !== e.in_range)
                report($sformatf("in_range %0b want %0b", got.in_range, e.in_range));
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_start;
    logic                            o_busy;
    hpfm_pkg::t_req                  i_req;
    logic                            o_done;
    hpfm_pkg::t_res                  o_res;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [hpfm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [hpfm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    map_scoreboard sb;
    int            cycles;
    int            idle_pct;

    homography_pixel_forward_map_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req(i_req), .o_done(o_done), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // watch both handshakes and the cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_start && !o_busy) sb.note(i_req);
            if (o_done) sb.check(o_res);
        end
    end

    // one request, with random idle cycles ahead of it
    task send_pixel(logic signed [11:0] x, logic signed [11:0] y, logic [7:0] pix);
        logic b;
        while ($urandom_range(99, 0) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= '{src_x: x, src_y: y, pixel_in: pix};
        forever begin
            @(negedge i_clk);
            b = o_busy;
            @(posedge i_clk);
            if (!b) break;
        end
    endtask

    task write_reg(logic [hpfm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        logic r;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(negedge i_clk);
            r = o_cfg_ready;
            @(posedge i_clk);
            if (r) break;
        end
    endtask

    // let the pipeline empty before the registers change
    task drain;
        i_start     <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_all(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2, logic [63:0] r3,
                   logic [63:0] r4, logic [63:0] c, logic [63:0] r);
        write_reg(hpfm_pkg::REG_ROW0_A, r0);
        write_reg(hpfm_pkg::REG_ROW0B_ROW1A, r1);
        write_reg(hpfm_pkg::REG_ROW1_B, r2);
        write_reg(hpfm_pkg::REG_ROW2_A, r3);
        write_reg(hpfm_pkg::REG_ROW2_C, r4);
        write_reg(hpfm_pkg::REG_OUT_COLS, c);
        write_reg(hpfm_pkg::REG_OUT_ROWS, r);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [31:0] coef_near(int centre, int span);
        return 32'(centre + int'($urandom_range(2 * span, 0)) - span);
    endfunction

    function logic [63:0] pick_limit();
        case ($urandom_range(5, 0))
            0: return 64'd1;
            1: return 64'd4096;
            2: return 64'($urandom_range(8191, 4097));
            default: return 64'($urandom_range(1500, 300));
        endcase
    endfunction

    initial begin
        logic [63:0] r0, r1, r2, r3, r4;
        logic signed [11:0] x, y;
        sb = new();
        cycles = 0;
        idle_pct = 7;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset mapping: identity shifted by the offset, edges of both axes
        send_pixel(-12'sd2048, -12'sd2048, 8'h00);
        send_pixel(12'sd2047, 12'sd2047, 8'hff);
        send_pixel(12'sd0, 12'sd0, 8'h5a);
        send_pixel(-12'sd500, 12'sd0, 8'h01);
        send_pixel(-12'sd499, -12'sd499, 8'h80);
        send_pixel(12'sd523, 12'sd523, 8'h7f);
        send_pixel(12'sd524, 12'sd0, 8'hfe);
        drain();

        // half scale: rounding half up and clamping back below the limit
        write_all(64'h0000_0000_0008_0000, 64'h0, 64'h0000_0000_0008_0000, 64'h0,
                  64'h0010_0000, 64'd501, 64'd501);
        send_pixel(12'sd1, 12'sd1, 8'h11);
        send_pixel(-12'sd1, -12'sd1, 8'h22);
        send_pixel(12'sd2, -12'sd3, 8'h33);
        send_pixel(-12'sd999, -12'sd1000, 8'h44);
        send_pixel(-12'sd1001, 12'sd0, 8'h55);
        drain();

        // zero denominator, limits at and above the maximum and a write to an unused index
        write_all(64'h0000_0000_0010_0000, 64'h0, 64'h0000_0000_0010_0000, 64'h0,
                  64'h0, 64'd4096, 64'd8191);
        write_reg(REG_SPARE, 64'hffff_ffff_ffff_ffff);
        i_cfg_valid <= 1'b0;
        send_pixel(12'sd0, 12'sd0, 8'h99);
        send_pixel(12'sd100, -12'sd7, 8'haa);
        drain();

        // zero width makes every pixel fall outside
        write_all(64'h0000_0000_0010_0000, 64'h0, 64'h0000_0000_0010_0000, 64'h0,
                  64'h0010_0000, 64'd0, 64'd1);
        send_pixel(12'sd0, 12'sd0, 8'hc3);
        send_pixel(-12'sd500, -12'sd500, 8'h3c);
        drain();

        // random homographies, mostly mild perspective so results land in the image
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_pct = (ph < 4) ? 7 : (ph < 8) ? 62 : 0;
            if (ph % 4 == 3) begin
                r0 = {$urandom, $urandom};
                r1 = {$urandom, $urandom};
                r2 = {$urandom, $urandom};
                r3 = {$urandom, $urandom};
                r4 = {32'($urandom), 32'($urandom)};
            end else begin
                r0 = {coef_near(0, 1 << 19), coef_near(0, 1 << 21)};
                r1 = {coef_near(0, 1 << 19), coef_near(0, 200 << 20)};
                r2 = {coef_near(0, 200 << 20), coef_near(0, 1 << 21)};
                r3 = {coef_near(0, 1 << 10), coef_near(0, 1 << 10)};
                r4 = {32'($urandom), coef_near(($urandom_range(3, 0) == 0) ? -(1 << 20)
                                               : (1 << 20), 1 << 19)};
            end
            write_all(r0, r1, r2, r3, r4, pick_limit(), pick_limit());
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(9, 0) < 7) begin
                    x = 12'($signed($urandom_range(1400, 0)) - 700);
                    y = 12'($signed($urandom_range(1400, 0)) - 700);
                end else begin
                    x = 12'($urandom);
                    y = 12'($urandom);
                end
                send_pixel(x, y, 8'($urandom));
            end
            drain();
        end

        if (sb.due_q.size() != 0)
            sb.report("results still outstanding at the end");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== homography_pixel_forward_map_unit.f =====
rtl/hpfm_pkg.sv
rtl/hpfm_cfg.sv
rtl/hpfm_mac.sv
rtl/hpfm_div.sv
rtl/hpfm_post.sv
rtl/homography_pixel_forward_map_unit.sv
tb/sv/tb_homography_pixel_forward_map_unit.sv
